### hdl/fpc_pkg.sv
`default_nettype none
package fpc_pkg;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        direction;
    logic [31:0] frame_counter;
    logic        last_byte;
  } in_data_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       result_last;
  } out_data_t;

  // register indexes of the configuration port
  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_DEV_ADDR = 2'd2;

  localparam logic [7:0] BLOCK_FLAGS  = 8'h01;
  localparam logic [3:0] LAST_ROUND   = 4'd10;
  localparam int         BLOCK_BYTES  = 16;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // multiply by x in GF(2^8)
  function automatic logic [7:0] xt(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

### hdl/fpc_aes.sv
`default_nettype none
module fpc_aes (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [127:0] key,
  input  wire logic [127:0] blk,
  output logic              done,
  output logic [127:0]      result
);

  logic [127:0] state_r;
  logic [127:0] rk_r;
  logic [127:0] rk_nxt;
  logic [127:0] rnd_out;
  logic [7:0]   rc_r;
  logic [3:0]   rnd_r;
  logic         busy_r;
  logic         done_r;

  // next round key, expanded on the fly
  always_comb begin
    logic [31:0] w0, w1, w2, w3;
    w0 = rk_r[127:96] ^ {fpc_pkg::SBOX[rk_r[23:16]] ^ rc_r, fpc_pkg::SBOX[rk_r[15:8]],
                         fpc_pkg::SBOX[rk_r[7:0]], fpc_pkg::SBOX[rk_r[31:24]]};
    w1 = rk_r[95:64] ^ w0;
    w2 = rk_r[63:32] ^ w1;
    w3 = rk_r[31:0] ^ w2;
    rk_nxt = {w0, w1, w2, w3};
  end

  // sub bytes, shift rows, mix columns (mix columns skipped in the last round)
  always_comb begin
    logic [7:0] st [16];
    logic [7:0] sb [16];
    logic [7:0] a0, a1, a2, a3, all;
    for (int i = 0; i < 16; i++) begin
      st[i] = state_r[127 - 8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        sb[c*4 + j] = fpc_pkg::SBOX[st[((c + j) % 4)*4 + j]];
      end
    end
    rnd_out = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = sb[c*4];
      a1 = sb[c*4 + 1];
      a2 = sb[c*4 + 2];
      a3 = sb[c*4 + 3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (rnd_r == fpc_pkg::LAST_ROUND) begin
        rnd_out[127 - 32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        rnd_out[127 - 32*c -: 32] = {a0 ^ all ^ fpc_pkg::xt(a0 ^ a1),
                                     a1 ^ all ^ fpc_pkg::xt(a1 ^ a2),
                                     a2 ^ all ^ fpc_pkg::xt(a2 ^ a3),
                                     a3 ^ all ^ fpc_pkg::xt(a3 ^ a0)};
      end
    end
  end

  // round sequencer, one round a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= 4'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rnd_r  <= 4'd1;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 4'd1;
        if (rnd_r == fpc_pkg::LAST_ROUND) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      state_r <= blk ^ key;
      rk_r    <= key;
      rc_r    <= 8'h01;
    end else if (busy_r) begin
      state_r <= rnd_out ^ rk_nxt;
      rk_r    <= rk_nxt;
      rc_r    <= fpc_pkg::xt(rc_r);
    end
  end

  assign done   = done_r;
  assign result = state_r;

endmodule
`default_nettype wire

### hdl/fpc_ksm.sv
`default_nettype none
module fpc_ksm (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         load,
  input  wire logic         abort,
  input  wire logic [127:0] blk,
  input  wire logic         rd_en,
  input  wire logic [3:0]   rd_addr,
  output logic [7:0]        rd_data,
  output logic              rd_hit
);

  logic [7:0] mem [16];
  logic [7:0] rd_data_r;
  logic [4:0] fill_r;
  logic       active_r;
  logic [3:0] wr_addr;

  assign wr_addr = fill_r[3:0];

  // copy sweep of a fresh keystream block into the memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= 5'd0;
      active_r <= 1'b0;
    end else if (abort) begin
      fill_r   <= 5'd0;
      active_r <= 1'b0;
    end else if (load) begin
      fill_r   <= 5'd0;
      active_r <= 1'b1;
    end else if (active_r) begin
      fill_r <= fill_r + 5'd1;
      if (fill_r == 5'(fpc_pkg::BLOCK_BYTES - 1)) begin
        active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active_r && !abort && !load) begin
      mem[wr_addr] <= blk[{~wr_addr, 3'b000} +: 8];
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // entry already copied before this cycle
  assign rd_hit  = {1'b0, rd_addr} < fill_r;
  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### hdl/frame_payload_ctr_cipher.sv
`default_nettype none
// channel  | direction | handshake          | payload
// in_      | input     | in_valid/in_stall  | fpc_pkg::in_data_t
// out_     | output    | out_valid/out_stall| fpc_pkg::out_data_t
// cfg_     | input     | apb, pready high   | 64-bit registers at 8*index
// Bytes inside a keystream block stream at one per cycle while out_stall is low.
// The first byte of each 16-byte block waits for the iterative
// AES core (10 rounds, one per cycle, keys expanded on the fly); otherwise a
// byte passes the holding stage, the read stage and the result register.
// Synchronous reset returns to awaiting a message's first byte.
// out_stall backs up through the result register, the read stage and the
// holding stage to in_stall.
module frame_payload_ctr_cipher (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire fpc_pkg::in_data_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output fpc_pkg::out_data_t      out_data,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [4:0]         cfg_paddr,
  input  wire logic [63:0]        cfg_pwdata,
  output logic [63:0]             cfg_prdata,
  output logic                    cfg_pready
);

  logic [63:0] key_hi_r, key_lo_r;
  logic [31:0] addr_r;
  logic [1:0]  cfg_idx;
  logic        cfg_wr;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      addr_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        fpc_pkg::REG_KEY_HIGH: key_hi_r <= cfg_pwdata;
        fpc_pkg::REG_KEY_LOW:  key_lo_r <= cfg_pwdata;
        fpc_pkg::REG_DEV_ADDR: addr_r   <= cfg_pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      fpc_pkg::REG_KEY_HIGH: cfg_prdata = key_hi_r;
      fpc_pkg::REG_KEY_LOW:  cfg_prdata = key_lo_r;
      fpc_pkg::REG_DEV_ADDR: cfg_prdata = {32'd0, addr_r};
      default:               cfg_prdata = '0;
    endcase
  end

  // message state
  logic [3:0]  pos_r;
  logic [7:0]  bn_r;
  logic        inmsg_r, dir_r;
  logic [31:0] ctr_r;
  logic        kv_r;

  // pipeline stages
  logic        h_v_r, r_v_r, out_v_r;
  logic [7:0]  h_byte_r, r_byte_r, r_fwd_r;
  logic        h_last_r, r_last_r, r_mem_r;
  logic [3:0]  h_pos_r;
  fpc_pkg::out_data_t out_r;

  logic        out_free, r_go, r_free, h_go, h_free, acc;
  logic        first;
  logic [3:0]  p;
  logic [7:0]  bn_cur, bn_new;
  logic        dir_use;
  logic [31:0] ctr_use;
  logic        aes_start, aes_done;
  logic [127:0] aes_blk, aes_res;
  logic [7:0]  rd_data;
  logic        rd_hit;

  assign out_free = !out_v_r || !out_stall;
  assign r_go     = r_v_r && out_free;
  assign r_free   = !r_v_r || r_go;
  assign h_go     = h_v_r && kv_r && r_free;
  assign h_free   = !h_v_r || h_go;
  assign in_stall = !h_free;
  assign acc      = in_valid && h_free;

  // position and block of the accepted byte
  assign first   = !inmsg_r;
  assign p       = first ? 4'd0 : pos_r;
  assign bn_cur  = first ? 8'd0 : bn_r;
  assign bn_new  = bn_cur + 8'd1;
  assign dir_use = first ? in_data.direction : dir_r;
  assign ctr_use = first ? in_data.frame_counter : ctr_r;
  assign aes_start = acc && (p == 4'd0);
  assign aes_blk = {fpc_pkg::BLOCK_FLAGS, 32'd0, 7'd0, dir_use,
                    addr_r[7:0], addr_r[15:8], addr_r[23:16], addr_r[31:24],
                    ctr_use[7:0], ctr_use[15:8], ctr_use[23:16], ctr_use[31:24],
                    8'h00, bn_new};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 4'd0;
      bn_r    <= 8'd0;
      inmsg_r <= 1'b0;
      dir_r   <= 1'b0;
      ctr_r   <= 32'd0;
      kv_r    <= 1'b0;
    end else begin
      if (aes_start) begin
        kv_r <= 1'b0;
      end else if (aes_done) begin
        kv_r <= 1'b1;
      end
      if (acc) begin
        if (first) begin
          dir_r <= in_data.direction;
          ctr_r <= in_data.frame_counter;
        end
        if (in_data.last_byte) begin
          pos_r   <= 4'd0;
          bn_r    <= 8'd0;
          inmsg_r <= 1'b0;
        end else begin
          pos_r   <= p + 4'd1;
          bn_r    <= (p == 4'd0) ? bn_new : bn_cur;
          inmsg_r <= 1'b1;
        end
      end
    end
  end

  fpc_aes u_aes (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (aes_start),
    .key    ({key_hi_r, key_lo_r}),
    .blk    (aes_blk),
    .done   (aes_done),
    .result (aes_res)
  );

  fpc_ksm u_ksm (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (aes_done),
    .abort   (aes_start),
    .blk     (aes_res),
    .rd_en   (h_go),
    .rd_addr (h_pos_r),
    .rd_data (rd_data),
    .rd_hit  (rd_hit)
  );

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r   <= 1'b0;
      r_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (h_free) h_v_r <= acc;
      if (r_free) r_v_r <= h_go;
      if (out_free) out_v_r <= r_go;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (acc) begin
      h_byte_r <= in_data.payload_byte;
      h_last_r <= in_data.last_byte;
      h_pos_r  <= p;
    end
    if (h_go) begin
      r_byte_r <= h_byte_r;
      r_last_r <= h_last_r;
      r_mem_r  <= rd_hit;
      r_fwd_r  <= aes_res[{~h_pos_r, 3'b000} +: 8];
    end
    if (r_go) begin
      out_r.result_byte <= r_byte_r ^ (r_mem_r ? rd_data : r_fwd_r);
      out_r.result_last <= r_last_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

### hdl/fpc_chk.sv
`default_nettype none
module fpc_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire fpc_pkg::out_data_t out_data,
  input wire logic               cfg_pready
);

  // nothing leaves the block right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result transaction right after reset");

  // register port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("cfg_pready low");

  // stalled result transaction stays
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

endmodule

bind frame_payload_ctr_cipher fpc_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_data   (out_data),
  .cfg_pready (cfg_pready)
);
`default_nettype wire
